FILE: rtl/iafp_pkg.sv
// Package for the IMU angle frame parser: frame layout constants,
// result status codes and link levels. No dependencies.
package iafp_pkg;

    localparam int unsigned FRAME_BYTES = 11;

    localparam logic [7:0] HEADER_BYTE       = 8'h55;
    localparam logic [7:0] GAP_LIMIT_RST     = 8'd30;
    localparam logic [7:0] EXPECTED_TYPE_RST = 8'h53;

    localparam logic [3:0] TYPE_POS       = 4'd1;
    localparam logic [3:0] ANGLE_HIGH_POS = 4'd7;
    localparam logic [3:0] ANGLE_LOW_POS  = 4'd8;
    localparam logic [3:0] LAST_POS       = 4'(FRAME_BYTES - 1);
    localparam logic [3:0] HUNT_POS       = 4'd0;

    localparam logic [5:0] DEG_SCALE = 6'd45;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_TIMEOUT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        LINK_SILENT = 2'd0,
        LINK_BYTES  = 2'd1,
        LINK_FRAME  = 2'd2
    } t_link;

    typedef enum logic {
        CFG_GAP_LIMIT     = 1'b0,
        CFG_EXPECTED_TYPE = 1'b1
    } t_cfg_idx;

endpackage

FILE: rtl/iafp_in_if.sv
// Input channel of the IMU angle frame parser: one received byte or idle tick per word.
// Depends on iafp_pkg.
interface iafp_in_if;
    import iafp_pkg::*;

    logic       valid;
    logic       ready;
    t_op        op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

FILE: rtl/iafp_out_if.sv
// Result channel of the IMU angle frame parser: frame status, yaw and link state.
// Depends on iafp_pkg.
interface iafp_out_if;
    import iafp_pkg::*;

    logic               valid;
    logic               ready;
    t_status            frame_status;
    logic signed [15:0] yaw_raw;
    logic signed [16:0] yaw_degrees_q8;
    t_link              link_state;

    modport source (output valid, output frame_status, output yaw_raw,
                    output yaw_degrees_q8, output link_state, input ready);
    modport sink   (input valid, input frame_status, input yaw_raw,
                    input yaw_degrees_q8, input link_state, output ready);
endinterface

FILE: rtl/imu_angle_frame_parser_unit.sv
// A result word is registered: it is valid in the cycle after the byte or tick that causes it.
// Throughput: one input word per cycle; the output register frees as it is taken,
// so input stalls only while a finished result waits on o_res.ready.
// Reset (synchronous, i_rst_n low): hunting for header, link silent, output empty,
// gap limit 30, expected type 0x53.
// Depends on iafp_pkg, iafp_in_if, iafp_out_if.
module imu_angle_frame_parser_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  iafp_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    iafp_in_if.sink              i_in,
    iafp_out_if.source           o_res
);
    import iafp_pkg::*;

    logic [7:0] r_gap_limit;
    logic [7:0] r_expected_type;

    logic [3:0] r_byte_idx,   n_byte_idx;
    logic [7:0] r_sum,        n_sum;
    logic [7:0] r_type_byte,  n_type_byte;
    logic [7:0] r_angle_hi,   n_angle_hi;
    logic [7:0] r_angle_lo,   n_angle_lo;
    logic [7:0] r_gap_cnt,    n_gap_cnt;
    t_link      r_link,       n_link;

    logic               r_out_valid;
    t_status            r_status,  n_status;
    logic signed [15:0] r_yaw_raw, n_yaw_raw;
    logic signed [16:0] r_yaw_deg, n_yaw_deg;
    t_link              r_out_link;

    logic               accept;
    logic               res_fire;
    logic [8:0]         gap_next;
    logic signed [15:0] raw_word;
    logic signed [21:0] deg_prod;

    assign i_in.ready = !r_out_valid || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign gap_next = {1'b0, r_gap_cnt} + 9'd1;
    assign raw_word = $signed({r_angle_hi, r_angle_lo});
    // raw * 45, then >>> 5 by dropping the low bits (floor)
    assign deg_prod = 22'(raw_word) * $signed({16'd0, DEG_SCALE});

    always_comb begin
        n_byte_idx  = r_byte_idx;
        n_sum       = r_sum;
        n_type_byte = r_type_byte;
        n_angle_hi  = r_angle_hi;
        n_angle_lo  = r_angle_lo;
        n_gap_cnt   = r_gap_cnt;
        n_link      = r_link;
        n_status    = ST_VALID;
        n_yaw_raw   = '0;
        n_yaw_deg   = '0;
        res_fire    = 1'b0;

        if (accept) begin
            if (i_in.op == OP_TICK) begin
                if (r_byte_idx != HUNT_POS) begin
                    if (gap_next > {1'b0, r_gap_limit}) begin
                        n_byte_idx = HUNT_POS;
                        n_gap_cnt  = '0;
                        n_status   = ST_TIMEOUT;
                        res_fire   = 1'b1;
                    end else begin
                        n_gap_cnt = gap_next[7:0];
                    end
                end
            end else begin
                if (r_link == LINK_SILENT) begin
                    n_link = LINK_BYTES;
                end
                n_gap_cnt = '0;
                if (r_byte_idx == HUNT_POS) begin
                    if (i_in.data_byte == HEADER_BYTE) begin
                        n_byte_idx = 4'd1;
                        n_sum      = i_in.data_byte;
                    end
                end else if (r_byte_idx < LAST_POS) begin
                    if (r_byte_idx == TYPE_POS)       n_type_byte = i_in.data_byte;
                    if (r_byte_idx == ANGLE_HIGH_POS) n_angle_hi  = i_in.data_byte;
                    if (r_byte_idx == ANGLE_LOW_POS)  n_angle_lo  = i_in.data_byte;
                    n_sum      = r_sum + i_in.data_byte;
                    n_byte_idx = r_byte_idx + 4'd1;
                end else begin
                    // checksum byte closes the frame
                    n_byte_idx = HUNT_POS;
                    res_fire   = 1'b1;
                    if (r_type_byte != r_expected_type) begin
                        n_status = ST_BAD_TYPE;
                    end else if (r_sum != i_in.data_byte) begin
                        n_status = ST_BAD_SUM;
                    end else begin
                        n_link    = LINK_FRAME;
                        n_status  = ST_VALID;
                        n_yaw_raw = raw_word;
                        n_yaw_deg = deg_prod[21:5];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit     <= GAP_LIMIT_RST;
            r_expected_type <= EXPECTED_TYPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAP_LIMIT:     r_gap_limit     <= i_cfg_data;
                CFG_EXPECTED_TYPE: r_expected_type <= i_cfg_data;
                default:           r_gap_limit     <= r_gap_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx  <= HUNT_POS;
            r_sum       <= '0;
            r_type_byte <= '0;
            r_angle_hi  <= '0;
            r_angle_lo  <= '0;
            r_gap_cnt   <= '0;
            r_link      <= LINK_SILENT;
            r_out_valid <= 1'b0;
        end else begin
            r_byte_idx  <= n_byte_idx;
            r_sum       <= n_sum;
            r_type_byte <= n_type_byte;
            r_angle_hi  <= n_angle_hi;
            r_angle_lo  <= n_angle_lo;
            r_gap_cnt   <= n_gap_cnt;
            r_link      <= n_link;
            if (accept) begin
                r_out_valid <= res_fire;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_status   <= n_status;
            r_yaw_raw  <= n_yaw_raw;
            r_yaw_deg  <= n_yaw_deg;
            r_out_link <= n_link;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_status   = r_status;
    assign o_res.yaw_raw        = r_yaw_raw;
    assign o_res.yaw_degrees_q8 = r_yaw_deg;
    assign o_res.link_state     = r_out_link;

endmodule

FILE: verif/imu_angle_frame_parser_unit_tb.sv
// Testbench for imu_angle_frame_parser_unit: directed frames from a table, then random
// byte/tick streams over several register settings, checked against an in-bench parser model.
// Depends on iafp_pkg, iafp_in_if, iafp_out_if and the RTL top.
module imu_angle_frame_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iafp_pkg::*;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] yaw;
        logic signed [16:0] deg;
        t_link              link;
    } t_yaw_result;

    // one directed frame: lead byte, then the frame with optional ticks before byte gap_at
    typedef struct packed {
        logic [7:0]  lead;
        logic [3:0]  gap_at;
        logic [8:0]  gap_len;
        logic [3:0]  n_bytes;
        logic [7:0]  ftype;
        logic [15:0] yaw;
        logic [7:0]  fill;
        logic [7:0]  sum_flip;
        bit          typed;
        t_yaw_result want;
    } t_frame_case;

    localparam t_frame_case FRAME_CASES [10] = '{
        // wrong type first, so the link is still at bytes-seen; ticks while hunting
        '{8'hAA, 4'd0, 9'd2, 4'd11, 8'h54, 16'h0000, 8'h00, 8'h00, 1'b1,
          '{ST_BAD_TYPE, 16'sd0, 17'sd0, LINK_BYTES}},
        // gap of gap_limit+1 ticks after four bytes
        '{8'h00, 4'd4, 9'd31, 4'd4, 8'h53, 16'h0000, 8'h00, 8'h00, 1'b1,
          '{ST_TIMEOUT, 16'sd0, 17'sd0, LINK_BYTES}},
        '{8'hFF, 4'd0, 9'd0, 4'd11, 8'h53, 16'h7FFF, 8'h00, 8'h00, 1'b1,
          '{ST_VALID, 16'sh7FFF, 17'sd46078, LINK_FRAME}},
        '{8'h00, 4'd0, 9'd0, 4'd11, 8'h53, 16'h8000, 8'hFF, 8'h00, 1'b1,
          '{ST_VALID, 16'sh8000, -17'sd46080, LINK_FRAME}},
        '{8'hFF, 4'd0, 9'd0, 4'd11, 8'h53, 16'hFFFF, 8'h00, 8'h00, 1'b1,
          '{ST_VALID, -16'sd1, -17'sd2, LINK_FRAME}},
        // bad type and bad sum together: type wins
        '{8'h00, 4'd0, 9'd0, 4'd11, 8'h00, 16'h1234, 8'h00, 8'h01, 1'b1,
          '{ST_BAD_TYPE, 16'sd0, 17'sd0, LINK_FRAME}},
        '{8'h00, 4'd0, 9'd0, 4'd11, 8'h53, 16'h0102, 8'h00, 8'h80, 1'b1,
          '{ST_BAD_SUM, 16'sd0, 17'sd0, LINK_FRAME}},
        // header value as frame data, gap of exactly gap_limit
        '{8'h00, 4'd6, 9'd30, 4'd11, 8'h53, 16'h5555, 8'h55, 8'h00, 1'b0, '0},
        '{8'h00, 4'd10, 9'd29, 4'd11, 8'h53, 16'h0001, 8'h00, 8'h00, 1'b0, '0},
        '{8'h00, 4'd0, 9'd0, 4'd11, 8'h53, 16'hC4F3, 8'hAA, 8'h00, 1'b0, '0}
    };

    localparam int HOLD_CYCLES = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    t_cfg_idx   cfg_idx;
    logic [7:0] cfg_data;

    iafp_in_if  in_ch ();
    iafp_out_if res_ch ();

    imu_angle_frame_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    // parser model state
    logic [7:0] gap_lim;
    logic [7:0] want_type;
    logic [3:0] frm_pos;
    logic [7:0] frm_sum;
    logic [7:0] frm_type;
    logic [7:0] yaw_hi;
    logic [7:0] yaw_lo;
    logic [7:0] idle_ticks;
    t_link      link_now;

    t_yaw_result yaw_results_due [$];
    t_yaw_result typed_want;
    bit          use_typed;
    int          err_count;
    int          live_words;
    int          snd_idle_pct;
    int          rcv_stall_pct;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit parse_word(input t_op op, input logic [7:0] b,
                                      output t_yaw_result r);
        int prod;
        r = '0;
        if (op == OP_TICK) begin
            if (frm_pos == HUNT_POS)
                return 1'b0;
            if ({1'b0, idle_ticks} + 9'd1 > {1'b0, gap_lim}) begin
                frm_pos    = HUNT_POS;
                idle_ticks = '0;
                r.status   = ST_TIMEOUT;
                r.link     = link_now;
                return 1'b1;
            end
            idle_ticks = idle_ticks + 8'd1;
            return 1'b0;
        end
        if (link_now == LINK_SILENT)
            link_now = LINK_BYTES;
        idle_ticks = '0;
        if (frm_pos == HUNT_POS) begin
            if (b == HEADER_BYTE) begin
                frm_pos = 4'd1;
                frm_sum = b;
            end
            return 1'b0;
        end
        if (frm_pos < LAST_POS) begin
            if (frm_pos == TYPE_POS)       frm_type = b;
            if (frm_pos == ANGLE_HIGH_POS) yaw_hi = b;
            if (frm_pos == ANGLE_LOW_POS)  yaw_lo = b;
            frm_sum = frm_sum + b;
            frm_pos = frm_pos + 4'd1;
            return 1'b0;
        end
        // checksum word
        frm_pos = HUNT_POS;
        if (frm_type != want_type) begin
            r.status = ST_BAD_TYPE;
            r.link   = link_now;
            return 1'b1;
        end
        if (frm_sum != b) begin
            r.status = ST_BAD_SUM;
            r.link   = link_now;
            return 1'b1;
        end
        link_now = LINK_FRAME;
        r.status = ST_VALID;
        r.yaw    = {yaw_hi, yaw_lo};
        prod     = int'(r.yaw) * 45;
        r.deg    = 17'(prod >>> 5);
        r.link   = link_now;
        return 1'b1;
    endfunction

    function automatic logic [7:0] frame_sum(input logic [7:0] fb [11]);
        logic [7:0] s;
        s = '0;
        for (int k = 0; k < 10; k++)
            s = s + fb[k];
        return s;
    endfunction

    function automatic int gap_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 90 || gap_lim > 8'd40)
            return $urandom_range(1, 3);
        if (r < 95)
            return gap_lim;
        return gap_lim + 1;
    endfunction

    // called just after a falling edge; returns just after the falling edge past acceptance
    task automatic send_word(input t_op op, input logic [7:0] b);
        t_yaw_result r;
        bit          ignored;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid     = 1'b0;
            in_ch.op        = t_op'($urandom_range(0, 1));
            in_ch.data_byte = 8'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.op        = op;
        in_ch.data_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        ignored = (frm_pos == HUNT_POS) && !(op == OP_BYTE && b == HEADER_BYTE);
        if (!ignored)
            live_words++;
        if (parse_word(op, b, r))
            yaw_results_due.push_back(use_typed ? typed_want : r);
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(OP_TICK, 8'($urandom));
    endtask

    task automatic run_frame_case(input t_frame_case fc);
        logic [7:0] fb [11];
        fb[0] = HEADER_BYTE;
        fb[1] = fc.ftype;
        for (int k = 2; k < 10; k++)
            fb[k] = fc.fill;
        fb[7]  = fc.yaw[15:8];
        fb[8]  = fc.yaw[7:0];
        fb[10] = frame_sum(fb) ^ fc.sum_flip;
        use_typed  = fc.typed;
        typed_want = fc.want;
        send_word(OP_BYTE, fc.lead);
        for (int k = 0; k < fc.n_bytes; k++) begin
            if (k == fc.gap_at)
                send_ticks(fc.gap_len);
            send_word(OP_BYTE, fb[k]);
        end
        if (fc.gap_at >= fc.n_bytes)
            send_ticks(fc.gap_len);
        use_typed = 1'b0;
    endtask

    task automatic send_frame_rand();
        logic [7:0] fb [11];
        int         n;
        if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1))
                    send_word(OP_TICK, 8'($urandom));
                else
                    send_word(OP_BYTE, 8'($urandom));
            end
        end
        fb[0] = HEADER_BYTE;
        fb[1] = ($urandom_range(0, 99) < 80) ? want_type : 8'($urandom);
        for (int k = 2; k < 10; k++)
            fb[k] = ($urandom_range(0, 99) < 8) ? HEADER_BYTE : 8'($urandom);
        fb[10] = frame_sum(fb);
        if ($urandom_range(0, 99) >= 85)
            fb[10] = fb[10] ^ 8'($urandom_range(1, 255));
        n = ($urandom_range(0, 99) < 90) ? 11 : $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            if (k > 0)
                send_ticks(gap_pick());
            send_word(OP_BYTE, fb[k]);
        end
    endtask

    task automatic random_frames(input int budget);
        int start;
        start = live_words;
        while (live_words - start < budget)
            send_frame_rand();
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [7:0] v);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_GAP_LIMIT:     gap_lim = v;
            CFG_EXPECTED_TYPE: want_type = v;
        endcase
    endtask

    // drain all due results, let the last word settle, then reprogram
    task automatic start_phase(input logic [7:0] gap, input logic [7:0] ftype,
                               input int snd, input int rcv);
        in_ch.valid = 1'b0;
        while (yaw_results_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_write(CFG_GAP_LIMIT, gap);
        cfg_write(CFG_EXPECTED_TYPE, ftype);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req     = 1'b0;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_ch.ready = ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    initial begin : res_check
        t_yaw_result due;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (yaw_results_due.size() == 0) begin
                    $error("result word with none due: frame_status %0d", res_ch.frame_status);
                    err_count++;
                end else begin
                    due = yaw_results_due.pop_front();
                    if (res_ch.frame_status !== due.status) begin
                        $error("frame_status: expected %0d, got %0d",
                               due.status, res_ch.frame_status);
                        err_count++;
                    end
                    if (res_ch.yaw_raw !== due.yaw) begin
                        $error("yaw_raw: expected %0d, got %0d", due.yaw, res_ch.yaw_raw);
                        err_count++;
                    end
                    if (res_ch.yaw_degrees_q8 !== due.deg) begin
                        $error("yaw_degrees_q8: expected %0d, got %0d",
                               due.deg, res_ch.yaw_degrees_q8);
                        err_count++;
                    end
                    if (res_ch.link_state !== due.link) begin
                        $error("link_state: expected %0d, got %0d",
                               due.link, res_ch.link_state);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_GAP_LIMIT;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_BYTE;
        in_ch.data_byte = '0;
        hold_req        = 1'b0;
        use_typed       = 1'b0;
        typed_want      = '0;
        err_count       = 0;
        live_words      = 0;
        snd_idle_pct    = 0;
        rcv_stall_pct   = 0;
        gap_lim         = GAP_LIMIT_RST;
        want_type       = EXPECTED_TYPE_RST;
        frm_pos         = HUNT_POS;
        frm_sum         = '0;
        frm_type        = '0;
        yaw_hi          = '0;
        yaw_lo          = '0;
        idle_ticks      = '0;
        link_now        = LINK_SILENT;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (FRAME_CASES[i])
            run_frame_case(FRAME_CASES[i]);

        // widest gap limit: 255 ticks pass, the next one times out
        start_phase(8'd255, 8'h53, 0, 0);
        send_word(OP_BYTE, HEADER_BYTE);
        send_ticks(256);
        random_frames(55);

        start_phase(8'd0, 8'h00, 69, 0);
        random_frames(55);
        start_phase(8'd30, 8'hFF, 0, 69);
        random_frames(55);
        start_phase(8'd1, 8'($urandom), 17, 17);
        random_frames(55);
        start_phase(8'($urandom_range(2, 40)), 8'h53, 17, 17);
        random_frames(55);

        // long receiver hold-off while header+tick pairs keep timing out
        start_phase(8'd0, 8'h53, 0, 0);
        hold_req = 1'b1;
        repeat (24) begin
            send_word(OP_BYTE, HEADER_BYTE);
            send_word(OP_TICK, 8'($urandom));
        end
        random_frames(40);

        in_ch.valid = 1'b0;
        while (yaw_results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/iafp_pkg.sv
rtl/iafp_in_if.sv
rtl/iafp_out_if.sv
rtl/imu_angle_frame_parser_unit.sv
verif/imu_angle_frame_parser_unit_tb.sv
